// File: src/touch_detect_baseline_hysteresis_defines.svh
// Assertion macros shared by the touch detector checker.
`ifndef TOUCH_DETECT_BASELINE_HYSTERESIS_DEFINES_SVH
`define TOUCH_DETECT_BASELINE_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define TDBH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch detector check failed");

// Next-cycle implication, held off while in reset.
`define TDBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch detector check failed");

`endif

// File: src/tdbh_pkg.sv
// Types and constants for the touch detector.
package tdbh_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_ON_PCT   = 2'd1,
		REG_OFF_PCT  = 2'd2
	} reg_idx_t;

	localparam logic [7:0] DEBOUNCE_RST = 8'd3;
	localparam logic [6:0] ON_PCT_RST   = 7'd70;
	localparam logic [6:0] OFF_PCT_RST  = 7'd85;

	// percent scale on the sample side of the threshold compare
	localparam logic [6:0] PCT_SCALE = 7'd100;

	// floor(x / 100) = (x * DRIFT_RECIP) >> DRIFT_SHIFT, exact for x < 2^23
	localparam int          DRIFT_SHIFT = 30;
	localparam logic [23:0] DRIFT_RECIP = 24'd10737419;

	localparam int CALIB_RECIP_SHIFT = 26;

	typedef struct packed {
		logic [7:0] debounce;
		logic [6:0] on_pct;
		logic [6:0] off_pct;
	} cfg_t;

	typedef struct packed {
		logic touched;
		logic press;
		logic release_ev;
	} det_t;

endpackage

// File: src/tdbh_cfg_regs.sv
// Configuration register file: debounce count and the two thresholds.
module tdbh_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tdbh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdbh_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output tdbh_pkg::cfg_t                      cfg
);
	import tdbh_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce <= DEBOUNCE_RST;
			cfg_q.on_pct   <= ON_PCT_RST;
			cfg_q.off_pct  <= OFF_PCT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce <= cfg_wdata;
				REG_ON_PCT:   cfg_q.on_pct   <= cfg_wdata[6:0];
				REG_OFF_PCT:  cfg_q.off_pct  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/tdbh_calib.sv
// Initial calibration: sample count, running sum and the truncated mean.
module tdbh_calib #(
	parameter int CALIB_SAMPLES = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] sample,
	output logic        calibrating,
	output logic        last,
	output logic [15:0] mean
);
	import tdbh_pkg::*;

	localparam int CW = $clog2(CALIB_SAMPLES + 1);
	localparam int SW = $clog2(CALIB_SAMPLES * 65535 + 1);
	localparam int RW = CALIB_RECIP_SHIFT + 1;
	localparam int RECIP = (2**CALIB_RECIP_SHIFT + CALIB_SAMPLES - 1) / CALIB_SAMPLES;

	logic [CW-1:0]    count_q;
	logic [SW-1:0]    sum_q;
	logic [SW-1:0]    sum_next;
	logic [SW+RW-1:0] prod;

	assign calibrating = count_q < CW'(CALIB_SAMPLES);
	assign last        = count_q == CW'(CALIB_SAMPLES - 1);
	assign sum_next    = sum_q + SW'(sample);

	// reciprocal multiply; exact since sum * error stays below 2^shift
	assign prod = (SW+RW)'(sum_next) * (SW+RW)'(RW'(RECIP));
	assign mean = prod[CALIB_RECIP_SHIFT +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (step && calibrating) begin
			count_q <= count_q + CW'(1);
			sum_q   <= sum_next;
		end
	end

endmodule

// File: src/tdbh_detect.sv
// Threshold compare with hysteresis, debounce run counter and touch flag.
module tdbh_detect (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           run,
	input  logic [15:0]    sample,
	input  logic [15:0]    baseline,
	input  tdbh_pkg::cfg_t cfg,
	output tdbh_pkg::det_t det
);
	import tdbh_pkg::*;

	logic [7:0]  confirm_q;
	logic        touched_q;
	logic [22:0] lhs;
	logic [22:0] rhs;
	logic [6:0]  pct;
	logic        qual;
	logic [7:0]  cnt_inc;
	logic        confirm;
	logic [7:0]  confirm_next;

	assign pct  = touched_q ? cfg.off_pct : cfg.on_pct;
	assign lhs  = 23'(sample) * 23'(PCT_SCALE);
	assign rhs  = 23'(baseline) * 23'(pct);
	// untouched: below the on level counts; touched: at or above the off level
	assign qual = touched_q ? (lhs >= rhs) : (lhs < rhs);

	assign cnt_inc      = (confirm_q == 8'hFF) ? confirm_q : confirm_q + 8'd1;
	assign confirm      = run && qual && (cnt_inc >= cfg.debounce);
	assign confirm_next = (!qual || confirm) ? 8'd0 : cnt_inc;

	assign det.touched    = touched_q ^ confirm;
	assign det.press      = confirm && !touched_q;
	assign det.release_ev = confirm && touched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= '0;
			touched_q <= 1'b0;
		end else if (step && run) begin
			confirm_q <= confirm_next;
			touched_q <= det.touched;
		end
	end

endmodule

// File: src/tdbh_drift.sv
// Baseline drift: floor((baseline * 99 + sample) / 100).
module tdbh_drift (
	input  logic [15:0] baseline,
	input  logic [15:0] sample,
	output logic [15:0] drifted
);
	import tdbh_pkg::*;

	logic [22:0] x;
	logic [46:0] prod;

	// baseline * 99 as 64b + 32b + 2b + b
	assign x = (23'(baseline) << 6) + (23'(baseline) << 5) + (23'(baseline) << 1)
		+ 23'(baseline) + 23'(sample);

	assign prod    = 47'(x) * 47'(DRIFT_RECIP);
	assign drifted = prod[DRIFT_SHIFT +: 16];

endmodule

// File: src/touch_detect_baseline_hysteresis.sv
// Top level of the capacitive touch detector with baseline tracking.
//
// Input channel: sample, qualified by in_valid / in_stall. A beat moves when
// in_valid is high and in_stall is low. Output channel: one result beat per
// input beat (calibrating, touched, press_event, release_event,
// baseline_value) on out_valid / out_stall, in input order.
//
// Each beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low, set by the
// combinational state update (baseline, debounce counter, touch flag)
// between the two registers, through which the baseline recurrence closes.
//
// Reset (arst_n low) clears calibration, baseline, debounce state and both
// valid bits; registers return to debounce 3, on 70%, off 85%. The first
// CALIB_SAMPLES beats calibrate the baseline.
//
// If out_stall holds a result, an empty input register still takes one more
// beat; then in_stall rises until the result drains. Configuration is
// written through cfg_we / cfg_index / cfg_wdata, by the user only while the
// block is idle; it is not enforced. Writes to unknown indexes are dropped.
module touch_detect_baseline_hysteresis #(
	parameter int CALIB_SAMPLES = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [tdbh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdbh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [15:0]                        sample,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               calibrating,
	output logic                               touched,
	output logic                               press_event,
	output logic                               release_event,
	output logic [15:0]                        baseline_value
);
	import tdbh_pkg::*;

	cfg_t        cfg;
	det_t        det;

	// input register
	logic        valid_s1;
	logic [15:0] sample_s1;
	// result register
	logic        valid_s2;
	logic        calib_s2;
	logic        touched_s2;
	logic        press_s2;
	logic        release_s2;
	logic [15:0] baseline_s2;

	logic [15:0] baseline_q;
	logic [15:0] baseline_next;
	logic [15:0] drifted;
	logic [15:0] mean;
	logic        cal_active;
	logic        cal_last;

	logic        advance;   // result register may load
	logic        s1_load;   // input register may load
	logic        step;      // item in s1 is processed this cycle

	assign advance  = !valid_s2 || !out_stall;
	assign s1_load  = !valid_s1 || advance;
	assign in_stall = !s1_load;
	assign step     = valid_s1 && advance;

	tdbh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tdbh_calib #(
		.CALIB_SAMPLES (CALIB_SAMPLES)
	) u_calib (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.sample      (sample_s1),
		.calibrating (cal_active),
		.last        (cal_last),
		.mean        (mean)
	);

	tdbh_detect u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.run      (!cal_active),
		.sample   (sample_s1),
		.baseline (baseline_q),
		.cfg      (cfg),
		.det      (det)
	);

	tdbh_drift u_drift (
		.baseline (baseline_q),
		.sample   (sample_s1),
		.drifted  (drifted)
	);

	// baseline: mean on the last calibration beat, drift while untouched
	always_comb begin
		baseline_next = baseline_q;
		if (cal_active) begin
			if (cal_last) begin
				baseline_next = mean;
			end
		end else if (!det.touched) begin
			baseline_next = drifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			baseline_q <= '0;
		end else begin
			if (s1_load) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				baseline_q <= baseline_next;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			sample_s1 <= sample;
		end
		if (step) begin
			calib_s2    <= cal_active;
			touched_s2  <= det.touched;
			press_s2    <= det.press;
			release_s2  <= det.release_ev;
			baseline_s2 <= baseline_next;
		end
	end

	assign out_valid      = valid_s2;
	assign calibrating    = calib_s2;
	assign touched        = touched_s2;
	assign press_event    = press_s2;
	assign release_event  = release_s2;
	assign baseline_value = baseline_s2;

endmodule

// File: src/tdbh_checker.sv
// Port-level checker for the touch detector, bound to the top level.
`include "touch_detect_baseline_hysteresis_defines.svh"

module tdbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        calibrating,
	input logic        touched,
	input logic        press_event,
	input logic        release_event,
	input logic [15:0] baseline_value
);

	`TDBH_ASSERT_NOW(a_single_event, clk, arst_n, out_valid, !(press_event && release_event))
	`TDBH_ASSERT_NOW(a_press_state, clk, arst_n, out_valid && press_event, touched && !calibrating)
	`TDBH_ASSERT_NOW(a_release_state, clk, arst_n, out_valid && release_event, !touched && !calibrating)
	`TDBH_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(baseline_value))

endmodule

bind touch_detect_baseline_hysteresis tdbh_checker u_tdbh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.calibrating    (calibrating),
	.touched        (touched),
	.press_event    (press_event),
	.release_event  (release_event),
	.baseline_value (baseline_value)
);
